>>> hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [15:0] KEEP_MASK    = 16'hF0FF;
    localparam logic [15:0] FG_MASK      = 16'h0F00;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  char_code;
        logic [7:0]  color_attr;
        logic [10:0] cell_index;
    } item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_pos;
        logic [15:0] cell_data;
        logic        scrolled;
    } result_t;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ,
        CMD_READ_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  char_code;
        logic [7:0]  color_attr;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CHAR_FG,
        BK_READ,
        BK_SCROLL
    } back_state_t;

endpackage

>>> hdl/tcw_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int CELLS = 2000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       item,
    input  logic        pop,
    output queue_head_t head,
    output logic        full
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.char_code  = item.char_code & BYTE_MASK;
        cmd_in.color_attr = item.color_attr;
        cmd_in.cell_index = item.cell_index;
        if (item.op)
        begin
            if (32'(item.cell_index) < 32'(CELLS))
                cmd_in.kind = CMD_READ;
            else
                cmd_in.kind = CMD_READ_NONE;
        end
        else if (item.char_code == NEWLINE_CHAR)
        begin
            cmd_in.kind = CMD_NEWLINE;
        end
        else
        begin
            cmd_in.kind = CMD_PUT;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cmd_in;
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule

>>> hdl/tcw_back.sv
// Back end: cell buffer memory, cursor, and the sequencer that executes queued commands.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        clearing,
    output logic        done,
    output result_t     result
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_POS = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] MOVE_LIMIT   = AW'(CELLS - COLUMNS);

    logic [15:0] mem [CELLS];

    back_state_t state_reg;
    back_state_t state_next;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    cmd_t          cur_reg;
    cmd_t          cur_next;
    logic          done_reg;
    logic          done_next;
    result_t       result_reg;
    result_t       result_next;
    logic [15:0]   rdata_reg;

    logic          we;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic          do_advance;
    logic          start_scroll;
    logic          emit;
    logic [15:0]   emit_data;
    logic          emit_scrolled;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          wrap;
    logic          row_end;
    logic [AW:0]   look_ahead;

    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign wrap       = (col_inc == (CW + 1)'(COLUMNS));
    assign row_end    = (row_inc == (RW + 1)'(ROWS));
    assign look_ahead = {1'b0, sweep_reg} + (AW + 1)'(COLUMNS + 1);

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        we            = 1'b0;
        wr_addr       = sweep_reg;
        wr_data       = 16'h0000;
        rd_en         = 1'b0;
        rd_addr       = '0;
        pop           = 1'b0;
        do_advance    = 1'b0;
        start_scroll  = 1'b0;
        emit          = 1'b0;
        emit_data     = 16'h0000;
        emit_scrolled = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                we = 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = BK_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cur_next = head.cmd;
                    case (head.cmd.kind)
                        CMD_PUT:
                        begin
                            we      = 1'b1;
                            wr_addr = pos_reg;
                            wr_data = {head.cmd.color_attr, head.cmd.char_code};
                            if (pos_reg == LAST_CELL)
                            begin
                                do_advance = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_reg + 1'b1;
                                state_next = BK_CHAR_FG;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            if (row_end)
                            begin
                                start_scroll = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                col_next = '0;
                                pos_next = pos_reg - AW'(col_reg) + AW'(COLUMNS);
                                emit     = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(head.cmd.cell_index);
                            state_next = BK_READ;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_CHAR_FG:
            begin
                // merge the foreground nibble into the following cell
                we         = 1'b1;
                wr_addr    = pos_reg + 1'b1;
                wr_data    = (rdata_reg & KEEP_MASK) | ({cur_reg.color_attr, 8'h00} & FG_MASK);
                state_next = BK_IDLE;
                do_advance = 1'b1;
            end
            BK_READ:
            begin
                emit       = 1'b1;
                emit_data  = rdata_reg;
                state_next = BK_IDLE;
            end
            BK_SCROLL:
            begin
                // read runs one row ahead of the write pointer
                we      = 1'b1;
                wr_data = (sweep_reg < MOVE_LIMIT) ? rdata_reg : 16'h0000;
                if (look_ahead < (AW + 1)'(CELLS))
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(look_ahead);
                end
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next    = '0;
                    state_next    = BK_IDLE;
                    emit          = 1'b1;
                    emit_scrolled = 1'b1;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (do_advance)
        begin
            col_next = wrap ? '0 : col_reg + 1'b1;
            if (wrap && row_end)
            begin
                start_scroll = 1'b1;
            end
            else
            begin
                if (wrap)
                    row_next = row_reg + 1'b1;
                pos_next = pos_reg + 1'b1;
                emit     = 1'b1;
            end
        end

        if (start_scroll)
        begin
            row_next   = RW'(ROWS - 1);
            col_next   = '0;
            pos_next   = LAST_ROW_POS;
            sweep_next = '0;
            rd_en      = 1'b1;
            rd_addr    = AW'(COLUMNS);
            state_next = BK_SCROLL;
        end

        if (emit)
        begin
            done_next              = 1'b1;
            result_next.cursor_row = 5'(row_next);
            result_next.cursor_col = 7'(col_next);
            result_next.cursor_pos = 11'(pos_next);
            result_next.cell_data  = emit_data;
            result_next.scrolled   = emit_scrolled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            sweep_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign clearing = (state_reg == BK_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

>>> hdl/text_console_writer_unit.sv
// Top level of the text console writer: front queue, back sequencer, busy and result ports.
//
//  channel  | handshake          | payload           | direction
//  ---------+--------------------+-------------------+----------
//  command  | start high, busy low | item (item_t)   | in
//  result   | done, one cycle    | result (result_t) | out
//
// A read makes one memory read and an out-of-range read none; a put reads the next
// cell, if there is one, to merge its foreground nibble. A put or newline that scrolls
// copies one cell per cycle through the single write port of the cell memory.
// After reset the memory is zeroed with busy held high.
// A two-entry queue lets up to two transactions wait while the back end works;
// busy rises when it is full. Results cannot be held off by the receiver.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int CELLS = ROWS * COLUMNS;

    queue_head_t head;
    logic        pop;
    logic        full;
    logic        clearing;
    logic        push;

    assign busy = full || clearing;
    assign push = start && !busy;

    tcw_front #(
        .CELLS (CELLS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    // a scroll always leaves the cursor at the start of a row
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.scrolled |-> result.cursor_col == 7'd0)
        else $error("scroll left cursor off column zero");

    a_scroll_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.scrolled |-> result.cell_data == 16'h0000)
        else $error("scrolling put returned cell data");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done && !pop)
        else $error("activity during buffer clear");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> 32'(result.cursor_col) < COLUMNS)
        else $error("cursor column out of range");

endmodule
